FILE: src/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int TEXT_ROWS    = 25;
    localparam int TEXT_COLUMNS = 80;
    localparam int CELL_COUNT   = TEXT_ROWS * TEXT_COLUMNS;

    localparam int ROW_W  = $clog2(TEXT_ROWS + 1);
    localparam int COL_W  = $clog2(TEXT_COLUMNS + 1);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int LOC_FIELD_W = 11;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_RETURN  = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [15:0] BLANK_RESET = 16'h0F20;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_EN  = 2'd2;

    typedef logic [2:0] t_cmd_kind;
    localparam t_cmd_kind CMD_NOP     = 3'd0;
    localparam t_cmd_kind CMD_GLYPH   = 3'd1;
    localparam t_cmd_kind CMD_NEWLINE = 3'd2;
    localparam t_cmd_kind CMD_RETURN  = 3'd3;
    localparam t_cmd_kind CMD_CLEAR   = 3'd4;
    localparam t_cmd_kind CMD_READ    = 3'd5;

    typedef struct packed {
        logic [1:0]             operation;
        logic [7:0]             char_code;
        logic                   end_of_string;
        logic [ROW_FIELD_W-1:0] read_row;
        logic [COL_FIELD_W-1:0] read_column;
    } t_in_item;

    typedef struct packed {
        logic [15:0]            cell_data;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_column;
        logic [LOC_FIELD_W-1:0] cursor_location;
        logic                   cursor_updated;
        logic                   cursor_hidden;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind              kind;
        logic                   is_put;
        logic                   eos;
        logic [7:0]             glyph;
        logic [ROW_FIELD_W-1:0] rd_row;
        logic [COL_FIELD_W-1:0] rd_col;
        logic                   rd_ok;
    } t_cmd;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

FILE: src/tccw_front.sv
// Front end: accepts input requests, decodes them into commands and
// holds them in a short command queue. Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tccw_pkg::t_in_item     i_item,
    input  logic                   i_push,
    output logic                   o_full,
    input  tccw_pkg::t_back_status i_status,
    output tccw_pkg::t_cmd         o_cmd,
    output logic                   o_cmd_valid,
    input  logic                   i_cmd_pop
);
    import tccw_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic              r_wp, n_wp;
    logic              r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    t_cmd              dec;
    logic              accept;
    logic              take;

    always_comb begin
        dec        = '0;
        dec.is_put = (i_item.operation == OP_PUT);
        dec.eos    = i_item.end_of_string;
        dec.glyph  = i_item.char_code;
        dec.rd_row = i_item.read_row;
        dec.rd_col = i_item.read_column;
        dec.rd_ok  = (i_item.read_row < ROW_FIELD_W'(TEXT_ROWS)) &&
                     (i_item.read_column < COL_FIELD_W'(TEXT_COLUMNS));
        unique case (i_item.operation)
            OP_PUT: begin
                if (i_item.char_code == CHAR_NEWLINE) begin
                    dec.kind = CMD_NEWLINE;
                end else if (i_item.char_code == CHAR_RETURN) begin
                    dec.kind = CMD_RETURN;
                end else begin
                    dec.kind = CMD_GLYPH;
                end
            end
            OP_CLEAR: dec.kind = CMD_CLEAR;
            OP_READ:  dec.kind = CMD_READ;
            default:  dec.kind = CMD_NOP;
        endcase
    end

    assign o_full      = (r_cnt == QCNT_W'(QUEUE_DEPTH)) || i_status.init_busy;
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign take        = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp  = accept ? !r_wp : r_wp;
        n_rp  = take ? !r_rp : r_rp;
        n_cnt = r_cnt + QCNT_W'(accept) - QCNT_W'(take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

FILE: src/tccw_out_queue.sv
// Result queue: two-entry buffer between the back end and the result port.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tccw_pkg::t_out_item i_item,
    input  logic                i_push,
    output logic                o_full,
    output tccw_pkg::t_out_item o_item,
    output logic                o_empty,
    input  logic                i_pop
);
    import tccw_pkg::*;

    t_out_item         r_q [QUEUE_DEPTH];
    logic              r_wp;
    logic              r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              accept;
    logic              take;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign accept  = i_push && !o_full;
    assign take    = i_pop && !o_empty;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wp <= !r_wp;
            end
            if (take) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + QCNT_W'(accept) - QCNT_W'(take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

FILE: src/tccw_back.sv
// Back end: executes commands against the cell store, keeps position,
// scroll origin, cursor and colour registers. Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tccw_pkg::t_cfg_wr      i_cfg,
    input  tccw_pkg::t_cmd         i_cmd,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_pop,
    output tccw_pkg::t_out_item    o_res,
    output logic                   o_res_push,
    input  logic                   i_res_full,
    output tccw_pkg::t_back_status o_status
);
    import tccw_pkg::*;

    localparam int SUM_W = ROW_W + 1;

    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_SCROLL  = 3'd2;
    localparam logic [2:0] ST_GL_WRAP = 3'd3;
    localparam logic [2:0] ST_GL_PUT  = 3'd4;
    localparam logic [2:0] ST_NL_FIN  = 3'd5;
    localparam logic [2:0] ST_CLEAR   = 3'd6;
    localparam logic [2:0] ST_READ    = 3'd7;

    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] top,
                                                    input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= SUM_W'(TEXT_ROWS)) begin
            sum = sum - SUM_W'(TEXT_ROWS);
        end
        return ADDR_W'(sum) * ADDR_W'(TEXT_COLUMNS) + ADDR_W'(col);
    endfunction

    logic [15:0]       mem [CELL_COUNT];
    logic [15:0]       r_rdata;

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_ret, n_ret;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_top, n_top;
    logic [ADDR_W-1:0] r_top_base, n_top_base;
    logic              r_shown, n_shown;
    t_cmd              r_cmd, n_cmd;
    logic [3:0]        r_bg;
    logic [3:0]        r_fg;
    logic              r_cur_en;

    t_cmd              cur;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] cell_addr;
    logic [15:0]       glyph_cell;
    logic [15:0]       blank_cell;
    logic              finish;
    logic [15:0]       fin_data;
    logic [ADDR_W-1:0] loc;
    logic              upd;
    logic              row_past;
    logic              col_full;

    assign cur        = (r_state == ST_IDLE) ? i_cmd : r_cmd;
    assign glyph_cell = {r_bg, r_fg, cur.glyph};
    assign blank_cell = {r_bg, r_fg, CHAR_SPACE};
    assign cell_addr  = phys_addr(r_top, r_row, r_col);
    assign mem_raddr  = phys_addr(r_top, ROW_W'(i_cmd.rd_row), COL_W'(i_cmd.rd_col));
    assign row_past   = (r_row >= ROW_W'(TEXT_ROWS));
    assign col_full   = (r_col >= COL_W'(TEXT_COLUMNS));

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_cnt      = r_cnt;
        n_row      = r_row;
        n_col      = r_col;
        n_top      = r_top;
        n_top_base = r_top_base;
        n_shown    = r_shown;
        n_cmd      = r_cmd;
        mem_we     = 1'b0;
        mem_waddr  = cell_addr;
        mem_wdata  = glyph_cell;
        o_cmd_pop  = 1'b0;
        finish     = 1'b0;
        fin_data   = '0;

        unique case (r_state)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = BLANK_RESET;
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_cnt     = '0;
                    case (i_cmd.kind)
                        CMD_RETURN: begin
                            n_col  = '0;
                            finish = 1'b1;
                        end
                        CMD_NEWLINE: begin
                            if (row_past) begin
                                n_state = ST_SCROLL;
                                n_ret   = ST_NL_FIN;
                            end else begin
                                n_col  = '0;
                                n_row  = r_row + ROW_W'(1);
                                finish = 1'b1;
                            end
                        end
                        CMD_GLYPH: begin
                            if (col_full) begin
                                if (row_past) begin
                                    n_state = ST_SCROLL;
                                    n_ret   = ST_GL_WRAP;
                                end else begin
                                    n_state = ST_GL_WRAP;
                                end
                            end else if (row_past) begin
                                n_state = ST_SCROLL;
                                n_ret   = ST_GL_PUT;
                            end else begin
                                mem_we = 1'b1;
                                n_col  = r_col + COL_W'(1);
                                finish = 1'b1;
                            end
                        end
                        CMD_CLEAR: n_state = ST_CLEAR;
                        CMD_READ:  n_state = ST_READ;
                        default:   finish  = 1'b1;
                    endcase
                end
            end
            ST_SCROLL: begin
                mem_we    = 1'b1;
                mem_waddr = r_top_base + r_cnt;
                mem_wdata = blank_cell;
                if (r_cnt == ADDR_W'(TEXT_COLUMNS - 1)) begin
                    if (r_top == ROW_W'(TEXT_ROWS - 1)) begin
                        n_top      = '0;
                        n_top_base = '0;
                    end else begin
                        n_top      = r_top + ROW_W'(1);
                        n_top_base = r_top_base + ADDR_W'(TEXT_COLUMNS);
                    end
                    n_row   = ROW_W'(TEXT_ROWS - 1);
                    n_col   = '0;
                    n_state = r_ret;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            ST_GL_WRAP: begin
                n_col   = '0;
                n_row   = r_row + ROW_W'(1);
                n_state = ST_GL_PUT;
            end
            ST_GL_PUT: begin
                if (row_past) begin
                    n_cnt   = '0;
                    n_state = ST_SCROLL;
                    n_ret   = ST_GL_PUT;
                end else begin
                    mem_we  = 1'b1;
                    n_col   = r_col + COL_W'(1);
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_NL_FIN: begin
                n_col   = '0;
                n_row   = r_row + ROW_W'(1);
                finish  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = blank_cell;
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    n_row      = '0;
                    n_col      = '0;
                    n_top      = '0;
                    n_top_base = '0;
                    finish     = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            ST_READ: begin
                fin_data = r_cmd.rd_ok ? r_rdata : 16'h0000;
                finish   = 1'b1;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        loc = '0;
        upd = 1'b0;
        if (finish && cur.is_put && cur.eos) begin
            if (!r_cur_en) begin
                n_shown = 1'b0;
            end else if ((n_row < ROW_W'(TEXT_ROWS)) && (n_col < COL_W'(TEXT_COLUMNS))) begin
                loc     = ADDR_W'(n_row) * ADDR_W'(TEXT_COLUMNS) + ADDR_W'(n_col);
                upd     = 1'b1;
                n_shown = 1'b1;
            end
        end
    end

    assign o_res_push             = finish;
    assign o_res.cell_data        = fin_data;
    assign o_res.cursor_row       = ROW_FIELD_W'(n_row);
    assign o_res.cursor_column    = COL_FIELD_W'(n_col);
    assign o_res.cursor_location  = LOC_FIELD_W'(loc);
    assign o_res.cursor_updated   = upd;
    assign o_res.cursor_hidden    = !n_shown;
    assign o_status.init_busy     = (r_state == ST_INIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_ret      <= ST_GL_PUT;
            r_cnt      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_top      <= '0;
            r_top_base <= '0;
            r_shown    <= 1'b1;
            r_bg       <= 4'h0;
            r_fg       <= 4'hF;
            r_cur_en   <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_cnt      <= n_cnt;
            r_row      <= n_row;
            r_col      <= n_col;
            r_top      <= n_top;
            r_top_base <= n_top_base;
            r_shown    <= n_shown;
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    CFG_BACKGROUND: r_bg     <= i_cfg.data;
                    CFG_FOREGROUND: r_fg     <= i_cfg.data;
                    CFG_CURSOR_EN:  r_cur_en <= i_cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == ST_IDLE) && !i_res_full)
        else $error("command taken outside idle or with result queue full");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    a_scroll_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) |->
            (r_ret == ST_GL_WRAP) || (r_ret == ST_GL_PUT) || (r_ret == ST_NL_FIN))
        else $error("scroll with bad return state");

    a_line_end_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_INIT) && (r_col == COL_W'(TEXT_COLUMNS)) |->
            (r_row < ROW_W'(TEXT_ROWS)))
        else $error("line end reached on pending bottom row");

    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT) |-> !o_cmd_pop && !o_res_push)
        else $error("activity during clearing pass");

endmodule

FILE: src/text_console_cell_writer_core.sv
// Top level of the text console cell writer: front decoder, back executor
// with cell store, result queue. Depends on tccw_pkg and the tccw_* modules.
// Flow: the front queue registers each request; the idle back end takes it when the
// result queue has room, pushing the result at once for glyphs, CR, LF and op 3. A read
// passes ST_READ, a wrap ST_GL_WRAP; scroll and clear blank cells via the single write
// port. Throughput: one request per cycle for glyphs without wrap or scroll while the
// result queue has room; none during a read. Reset: synchronous; afterwards a clearing
// pass of all CELL_COUNT (2000) cells fills the store with 0x0F20 while full stays high.
`timescale 1ns / 1ps

module text_console_cell_writer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tccw_pkg::t_in_item                   i_item,
    input  logic                                 push,
    output logic                                 full,
    output tccw_pkg::t_out_item                  o_result,
    output logic                                 empty,
    input  logic                                 pop,
    input  logic                                 i_cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tccw_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import tccw_pkg::*;

    t_cfg_wr      cfg;
    t_cmd         cmd;
    logic         cmd_valid;
    logic         cmd_pop;
    t_out_item    res;
    logic         res_push;
    logic         res_full;
    t_back_status status;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    tccw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_push      (push),
        .o_full      (full),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    tccw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_status    (status)
    );

    tccw_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (res),
        .i_push  (res_push),
        .o_full  (res_full),
        .o_item  (o_result),
        .o_empty (empty),
        .i_pop   (pop)
    );

endmodule
